FILE: rtl/plc_pkg.sv
// Shared types and constants for the positional list engine.
// Used by plc_cell and positional_list_engine; depends on nothing.
package plc_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] OP_INS_HEAD = 3'd0;
   localparam logic [2:0] OP_INS_TAIL = 3'd1;
   localparam logic [2:0] OP_INS_POS  = 3'd2;
   localparam logic [2:0] OP_DEL_POS  = 3'd3;
   localparam logic [2:0] OP_ROTATE   = 3'd4;
   localparam logic [2:0] OP_COUNT    = 3'd5;
   localparam logic [2:0] OP_DUMP     = 3'd6;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_BADPOS = 3'd1;
   localparam logic [2:0] STATUS_EMPTY  = 3'd2;
   localparam logic [2:0] STATUS_FULL   = 3'd3;
   localparam logic [2:0] STATUS_SHORT  = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] new_value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] item_value;
      logic [4:0]         item_count;
      logic               last_item;
   } rsp_type;

   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_NEW,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_WRAP
   } cell_sel_type;

   typedef enum logic [2:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_DELETE,
      CHAIN_ROTATE,
      CHAIN_DRAIN
   } chain_op_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_DUMP
   } state_type;

endpackage

FILE: rtl/plc_cell.sv
// One storage cell of the list chain: holds a value or loads a new, neighbour or wrap value.
// Depends on plc_pkg.
module plc_cell (
   input  logic                  clock,
   input  plc_pkg::cell_sel_type sel,
   input  logic signed [31:0]    left_value,
   input  logic signed [31:0]    right_value,
   input  logic signed [31:0]    new_value,
   input  logic signed [31:0]    wrap_value,
   output logic signed [31:0]    value_out
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      case (sel)
         plc_pkg::SEL_NEW:   value_in = new_value;
         plc_pkg::SEL_LEFT:  value_in = left_value;
         plc_pkg::SEL_RIGHT: value_in = right_value;
         plc_pkg::SEL_WRAP:  value_in = wrap_value;
         default:            value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

FILE: rtl/positional_list_engine.sv
// Positional list engine top level: a chain of plc_cell stages with the head in cell 0.
// Depends on plc_pkg and plc_cell.
// Insert, delete, rotation and count requests each give one result, so one request is
// accepted per cycle while the result register drains. A dump of a non-empty list holds
// off the request side until all elements are out: the chain rotates head to tail once
// per cycle while results drain and each element is read from cell 0, leaving the list
// unchanged after the last one. A dump of an empty list gives its single result like any
// other request; an untaken result stalls the engine. No clearing pass runs after reset.
module positional_list_engine #(
   parameter int DEPTH = plc_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  plc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plc_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

   plc_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       dump_left_ff, dump_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   plc_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   out_free;
   logic                   req_fire;
   logic                   dump_step;
   logic                   dump_start;
   logic [2:0]             op_status;
   logic [CNT_W-1:0]       op_count;
   plc_pkg::chain_op_type  op_chain;
   plc_pkg::chain_op_type  chain_op;
   logic [CMP_W-1:0]       cnt_ext;
   logic [CMP_W-1:0]       cnt_m1;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       ins_pos;
   logic signed [31:0]     tail_value;
   logic signed [31:0]     wrap_value;

   plc_pkg::cell_sel_type  cell_sel   [DEPTH];
   logic signed [31:0]     cell_value [DEPTH];

   assign cnt_ext    = CMP_W'(count_ff);
   assign cnt_m1     = cnt_ext - CMP_W'(1);
   assign pos_ext    = CMP_W'(req_data.position);
   assign tail_value = cell_value[IDX_W'(count_ff - CNT_W'(1))];
   assign wrap_value = (state_ff == plc_pkg::STATE_DUMP) ? cell_value[0] : tail_value;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   // decode the request
   always_comb begin
      op_status = plc_pkg::STATUS_OK;
      op_count  = count_ff;
      op_chain  = plc_pkg::CHAIN_HOLD;
      ins_pos   = pos_ext;
      unique case (req_data.op) inside
         plc_pkg::OP_INS_HEAD, plc_pkg::OP_INS_TAIL, plc_pkg::OP_INS_POS: begin
            if (req_data.op == plc_pkg::OP_INS_HEAD) begin
               ins_pos = '0;
            end else if (req_data.op == plc_pkg::OP_INS_TAIL) begin
               ins_pos = cnt_ext;
            end
            if (ins_pos > cnt_ext) begin
               op_status = plc_pkg::STATUS_BADPOS;
            end else if (count_ff >= CNT_W'(DEPTH)) begin
               op_status = plc_pkg::STATUS_FULL;
            end else begin
               op_chain = plc_pkg::CHAIN_INSERT;
               op_count = count_ff + CNT_W'(1);
            end
         end
         plc_pkg::OP_DEL_POS: begin
            if (count_ff == '0) begin
               op_status = plc_pkg::STATUS_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               op_status = plc_pkg::STATUS_BADPOS;
            end else begin
               op_chain = plc_pkg::CHAIN_DELETE;
               op_count = count_ff - CNT_W'(1);
            end
         end
         plc_pkg::OP_ROTATE: begin
            if (count_ff < CNT_W'(2)) begin
               op_status = plc_pkg::STATUS_SHORT;
            end else begin
               op_chain = plc_pkg::CHAIN_ROTATE;
            end
         end
         plc_pkg::OP_DUMP: begin
            if (count_ff == '0) begin
               op_status = plc_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            op_status = plc_pkg::STATUS_OK;
         end
      endcase
   end

   assign dump_start = req_fire && (req_data.op == plc_pkg::OP_DUMP) && (count_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plc_pkg::STATE_IDLE: begin
            if (dump_start) begin
               state_in = plc_pkg::STATE_DUMP;
            end
         end
         plc_pkg::STATE_DUMP: begin
            if (out_free && (dump_left_ff == CNT_W'(1))) begin
               state_in = plc_pkg::STATE_IDLE;
            end
         end
         default: state_in = plc_pkg::STATE_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      dump_step = 1'b0;
      unique case (state_ff)
         plc_pkg::STATE_IDLE: req_ready = out_free;
         plc_pkg::STATE_DUMP: dump_step = out_free;
         default: begin
            req_ready = 1'b0;
            dump_step = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (dump_step) begin
         chain_op = plc_pkg::CHAIN_DRAIN;
      end else if (req_fire) begin
         chain_op = op_chain;
      end else begin
         chain_op = plc_pkg::CHAIN_HOLD;
      end
   end

   always_comb begin
      count_in     = req_fire ? op_count : count_ff;
      dump_left_in = dump_left_ff;
      if (dump_start) begin
         dump_left_in = count_ff;
      end else if (dump_step) begin
         dump_left_in = dump_left_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_fire && !dump_start) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = op_status;
         rsp_in.item_value    = '0;
         rsp_in.item_count    = 5'(op_count);
         rsp_in.last_item     = 1'b1;
      end else if (dump_step) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = plc_pkg::STATUS_OK;
         rsp_in.item_value    = cell_value[0];
         rsp_in.item_count    = 5'(count_ff);
         rsp_in.last_item     = (dump_left_ff == CNT_W'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plc_pkg::STATE_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      always_comb begin
         cell_sel[i] = plc_pkg::SEL_HOLD;
         case (chain_op)
            plc_pkg::CHAIN_INSERT: begin
               if (CELL_IDX == ins_pos) begin
                  cell_sel[i] = plc_pkg::SEL_NEW;
               end else if ((CELL_IDX > ins_pos) && (CELL_IDX <= cnt_ext)) begin
                  cell_sel[i] = plc_pkg::SEL_LEFT;
               end
            end
            plc_pkg::CHAIN_DELETE: begin
               if ((CELL_IDX >= pos_ext) && (CELL_IDX < cnt_m1)) begin
                  cell_sel[i] = plc_pkg::SEL_RIGHT;
               end
            end
            plc_pkg::CHAIN_ROTATE: begin
               if (CELL_IDX == '0) begin
                  cell_sel[i] = plc_pkg::SEL_WRAP;
               end else if (CELL_IDX < cnt_ext) begin
                  cell_sel[i] = plc_pkg::SEL_LEFT;
               end
            end
            plc_pkg::CHAIN_DRAIN: begin
               if (CELL_IDX < cnt_m1) begin
                  cell_sel[i] = plc_pkg::SEL_RIGHT;
               end else if (CELL_IDX == cnt_m1) begin
                  cell_sel[i] = plc_pkg::SEL_WRAP;
               end
            end
            default: cell_sel[i] = plc_pkg::SEL_HOLD;
         endcase
      end

      plc_cell u_cell (
         .clock       (clock),
         .sel         (cell_sel[i]),
         .left_value  (left_value),
         .right_value (right_value),
         .new_value   (req_data.new_value),
         .wrap_value  (wrap_value),
         .value_out   (cell_value[i])
      );
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_no_req_in_dump : assert property (@(posedge clock) disable iff (reset)
      (state_ff == plc_pkg::STATE_DUMP) |-> !req_ready)
      else $error("request accepted during dump");

   a_count_stable_dump : assert property (@(posedge clock) disable iff (reset)
      (state_ff == plc_pkg::STATE_DUMP) |=> $stable(count_ff))
      else $error("count changed during dump");

   a_nonlast_in_dump : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_item) |-> (state_ff == plc_pkg::STATE_DUMP))
      else $error("non-final response outside dump");

endmodule
